// File: rtl/core/vcsf_pkg.sv
// Shared types, constants and register map for the velocity command safety filter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package vcsf_pkg;

  localparam int SPD_W  = 16;
  localparam int LIM_W  = 15;
  localparam int DIST_W = 16;
  localparam int FACT_W = 17;
  localparam int CAUSE_W = 4;
  localparam int MODE_W = 4;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int PROD_W = LIM_W + FACT_W;

  // divider: quotient of (n << 16) / d with n <= d, so 17 quotient bits
  localparam int Q_W              = FACT_W;
  localparam int DIV_BITS_PER_STG = 2;
  localparam int DIV_STAGES       = (Q_W + DIV_BITS_PER_STG - 1) / DIV_BITS_PER_STG;

  localparam logic [FACT_W-1:0] SIDE_MIN_FACTOR = 17'd13107;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE          = 4'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_LIMITED       = 4'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_FRONT_INVALID = 4'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_FRONT_STOP    = 4'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_FRONT_SLOW    = 4'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_LEFT_STOP     = 4'd5;
  localparam logic [CAUSE_W-1:0] CAUSE_LEFT_INVALID  = 4'd6;
  localparam logic [CAUSE_W-1:0] CAUSE_RIGHT_STOP    = 4'd7;
  localparam logic [CAUSE_W-1:0] CAUSE_RIGHT_INVALID = 4'd8;

  localparam logic [IDX_W-1:0] REG_MAX_LINEAR      = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_ANGULAR     = 3'd1;
  localparam logic [IDX_W-1:0] REG_FRONT_STOP_DIST = 3'd2;
  localparam logic [IDX_W-1:0] REG_FRONT_SLOW_DIST = 3'd3;
  localparam logic [IDX_W-1:0] REG_SIDE_STOP_DIST  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SIDE_SLOW_DIST  = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIN_FRONT_FACT  = 3'd6;
  localparam logic [IDX_W-1:0] REG_MODE_BITS       = 3'd7;

  localparam int MODE_ENABLE     = 0;
  localparam int MODE_FRONT_FAIL = 1;
  localparam int MODE_SIDE_FAIL  = 2;
  localparam int MODE_TURN_STOP  = 3;

  typedef struct packed {
    logic [LIM_W-1:0]  max_linear;
    logic [LIM_W-1:0]  max_angular;
    logic [DIST_W-1:0] front_stop_dist;
    logic [DIST_W-1:0] front_slow_dist;
    logic [DIST_W-1:0] side_stop_dist;
    logic [DIST_W-1:0] side_slow_dist;
    logic [FACT_W-1:0] min_front_factor;
    logic [MODE_W-1:0] mode_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_linear:       15'd500,
    max_angular:      15'd2000,
    front_stop_dist:  16'd300,
    front_slow_dist:  16'd800,
    side_stop_dist:   16'd200,
    side_slow_dist:   16'd500,
    min_front_factor: 17'd13107,
    mode_bits:        4'd15
  };

  typedef struct packed {
    logic signed [SPD_W-1:0] linear_cmd;
    logic signed [SPD_W-1:0] angular_cmd;
    logic [DIST_W-1:0]       front_dist;
    logic [DIST_W-1:0]       left_dist;
    logic [DIST_W-1:0]       right_dist;
    logic                    front_good;
    logic                    left_good;
    logic                    right_good;
  } cmd_t;

  // word state between decode and scaling
  typedef struct packed {
    logic signed [SPD_W-1:0] vf;
    logic signed [SPD_W-1:0] ws;
    logic                    f_slow;
    logic                    s_slow;
    logic                    limited;
    logic                    estop;
    logic [CAUSE_W-1:0]      cause;
  } side_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] linear_safe;
    logic signed [SPD_W-1:0] angular_safe;
    logic                    was_limited;
    logic                    estop;
    logic [CAUSE_W-1:0]      cause;
  } res_t;

endpackage

// File: rtl/core/vcsf_cmd_if.sv
// Command channel: valid/ready handshake with the velocity and range payload.
// Depends on vcsf_pkg for field widths.
`timescale 1ns / 1ps

interface vcsf_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vcsf_pkg::SPD_W-1:0]    linear_cmd;
  logic signed [vcsf_pkg::SPD_W-1:0]    angular_cmd;
  logic [vcsf_pkg::DIST_W-1:0]          front_dist;
  logic [vcsf_pkg::DIST_W-1:0]          left_dist;
  logic [vcsf_pkg::DIST_W-1:0]          right_dist;
  logic                                 front_good;
  logic                                 left_good;
  logic                                 right_good;

  modport source (
    output valid, linear_cmd, angular_cmd, front_dist, left_dist, right_dist,
           front_good, left_good, right_good,
    input  ready
  );
  modport sink (
    input  valid, linear_cmd, angular_cmd, front_dist, left_dist, right_dist,
           front_good, left_good, right_good,
    output ready
  );
endinterface

// File: rtl/core/vcsf_safe_if.sv
// Result channel: valid/ready handshake with the filtered command and status.
// Depends on vcsf_pkg for field widths.
`timescale 1ns / 1ps

interface vcsf_safe_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vcsf_pkg::SPD_W-1:0]    linear_safe;
  logic signed [vcsf_pkg::SPD_W-1:0]    angular_safe;
  logic                                 was_limited;
  logic                                 estop;
  logic [vcsf_pkg::CAUSE_W-1:0]         cause;

  modport source (
    output valid, linear_safe, angular_safe, was_limited, estop, cause,
    input  ready
  );
  modport sink (
    input  valid, linear_safe, angular_safe, was_limited, estop, cause,
    output ready
  );
endinterface

// File: rtl/core/vcsf_decode.sv
// First stage: absolute clamp, front and side rule decisions, cause priority,
// and the band numerators and spans for the dividers. Depends on vcsf_pkg.
`timescale 1ns / 1ps

module vcsf_decode #(
  parameter int TURN_LIMIT_AT_STOP = 1000
) (
  input  logic                          clk,
  input  logic                          en,
  input  vcsf_pkg::cmd_t                word,
  input  vcsf_pkg::cfg_t                cfg,
  output vcsf_pkg::side_t               side,
  output logic [vcsf_pkg::DIST_W-1:0]   f_num,
  output logic [vcsf_pkg::DIST_W-1:0]   f_den,
  output logic [vcsf_pkg::DIST_W-1:0]   s_num,
  output logic [vcsf_pkg::DIST_W-1:0]   s_den
);

  localparam logic signed [vcsf_pkg::SPD_W:0] TURN_LIM =
    (vcsf_pkg::SPD_W + 1)'(TURN_LIMIT_AT_STOP);

  logic signed [vcsf_pkg::SPD_W:0]  lin_x, ang_x, maxl_x, maxa_x, cv_x, cw_x, wf_x;
  logic                              clamp_hit, v_pos, f_valid, f_inv, f_stop, f_slow;
  logic                              left_on, right_on, s_valid, s_inv, s_stop, s_slow;
  logic [vcsf_pkg::DIST_W-1:0]       sd;
  logic                              sg;
  vcsf_pkg::side_t                   side_next;

  always_comb begin
    lin_x  = {word.linear_cmd[vcsf_pkg::SPD_W-1], word.linear_cmd};
    ang_x  = {word.angular_cmd[vcsf_pkg::SPD_W-1], word.angular_cmd};
    maxl_x = {2'b00, cfg.max_linear};
    maxa_x = {2'b00, cfg.max_angular};

    if (lin_x > maxl_x) cv_x = maxl_x;
    else if (lin_x < -maxl_x) cv_x = -maxl_x;
    else cv_x = lin_x;
    if (ang_x > maxa_x) cw_x = maxa_x;
    else if (ang_x < -maxa_x) cw_x = -maxa_x;
    else cw_x = ang_x;
    clamp_hit = (cv_x != lin_x) || (cw_x != ang_x);

    v_pos   = cv_x > 0;
    f_valid = word.front_good && (word.front_dist != '0);
    f_inv   = v_pos && !f_valid && cfg.mode_bits[vcsf_pkg::MODE_FRONT_FAIL];
    f_stop  = v_pos && f_valid && (word.front_dist <= cfg.front_stop_dist);
    f_slow  = v_pos && f_valid && (word.front_dist > cfg.front_stop_dist)
              && (word.front_dist <= cfg.front_slow_dist);

    if (f_stop) begin
      if (!cfg.mode_bits[vcsf_pkg::MODE_TURN_STOP]) wf_x = '0;
      else if (cw_x > TURN_LIM) wf_x = TURN_LIM;
      else if (cw_x < -TURN_LIM) wf_x = -TURN_LIM;
      else wf_x = cw_x;
    end else begin
      wf_x = cw_x;
    end

    left_on  = wf_x > 0;
    right_on = wf_x < 0;
    sd = left_on ? word.left_dist : word.right_dist;
    sg = left_on ? word.left_good : word.right_good;
    s_valid = sg && (sd != '0);
    s_inv   = (left_on || right_on) && !s_valid && cfg.mode_bits[vcsf_pkg::MODE_SIDE_FAIL];
    s_stop  = (left_on || right_on) && s_valid && (sd <= cfg.side_stop_dist);
    s_slow  = (left_on || right_on) && s_valid && (sd > cfg.side_stop_dist)
              && (sd <= cfg.side_slow_dist);

    if (cfg.mode_bits[vcsf_pkg::MODE_ENABLE]) begin
      side_next.vf      = (f_inv || f_stop) ? '0 : cv_x[vcsf_pkg::SPD_W-1:0];
      side_next.ws      = (s_inv || s_stop) ? '0 : wf_x[vcsf_pkg::SPD_W-1:0];
      side_next.f_slow  = f_slow;
      side_next.s_slow  = s_slow;
      side_next.limited = clamp_hit || f_inv || f_stop || f_slow || s_inv || s_stop || s_slow;
      side_next.estop   = f_inv || f_stop;
      if (clamp_hit) side_next.cause = vcsf_pkg::CAUSE_LIMITED;
      else if (f_inv) side_next.cause = vcsf_pkg::CAUSE_FRONT_INVALID;
      else if (f_stop) side_next.cause = vcsf_pkg::CAUSE_FRONT_STOP;
      else if (f_slow) side_next.cause = vcsf_pkg::CAUSE_FRONT_SLOW;
      else if (s_inv) side_next.cause = left_on ? vcsf_pkg::CAUSE_LEFT_INVALID
                                                : vcsf_pkg::CAUSE_RIGHT_INVALID;
      else if (s_stop) side_next.cause = left_on ? vcsf_pkg::CAUSE_LEFT_STOP
                                                 : vcsf_pkg::CAUSE_RIGHT_STOP;
      else if (s_slow) side_next.cause = vcsf_pkg::CAUSE_LIMITED;
      else side_next.cause = vcsf_pkg::CAUSE_NONE;
    end else begin
      side_next.vf      = word.linear_cmd;
      side_next.ws      = word.angular_cmd;
      side_next.f_slow  = 1'b0;
      side_next.s_slow  = 1'b0;
      side_next.limited = 1'b0;
      side_next.estop   = 1'b0;
      side_next.cause   = vcsf_pkg::CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side  <= side_next;
      f_num <= word.front_dist - cfg.front_stop_dist;
      f_den <= cfg.front_slow_dist - cfg.front_stop_dist;
      s_num <= sd - cfg.side_stop_dist;
      s_den <= cfg.side_slow_dist - cfg.side_stop_dist;
    end
  end

endmodule

// File: rtl/core/vcsf_div.sv
// Pipelined restoring divider: q = floor((num << 16) / den) for num <= den,
// two quotient bits per stage, one in the last stage. Depends on vcsf_pkg.
`timescale 1ns / 1ps

module vcsf_div (
  input  logic                                clk,
  input  logic [vcsf_pkg::DIV_STAGES-1:0]     en,
  input  logic [vcsf_pkg::DIST_W-1:0]         num,
  input  logic [vcsf_pkg::DIST_W-1:0]         den,
  output logic [vcsf_pkg::Q_W-1:0]            quo
);

  localparam int NS  = vcsf_pkg::DIV_STAGES;
  localparam int BPS = vcsf_pkg::DIV_BITS_PER_STG;
  localparam int DW  = vcsf_pkg::DIST_W;
  localparam int QW  = vcsf_pkg::Q_W;

  logic [DW-1:0] rem [NS];
  logic [DW-1:0] dvs [NS];
  logic [QW-1:0] qt  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic [DW-1:0] r_in, d_in, r_nx;
    logic [QW-1:0] q_in, q_nx;

    if (s == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[s-1];
      assign d_in = dvs[s-1];
      assign q_in = qt[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      logic        ge;
      r_nx = r_in;
      q_nx = q_in;
      for (int k = 0; k < BPS; k++) begin
        if (s * BPS + k < QW) begin
          t  = (s * BPS + k == 0) ? {1'b0, r_nx} : {r_nx, 1'b0};
          ge = t >= {1'b0, d_in};
          r_nx = ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
          q_nx = {q_nx[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem[s] <= r_nx;
        dvs[s] <= d_in;
        qt[s]  <= q_nx;
      end
    end
  end

  assign quo = qt[NS-1];

endmodule

// File: rtl/core/vcsf_scale.sv
// Last two stages: pick the band factor, multiply the magnitudes, then
// truncate, saturate, restore sign and select the result. Depends on vcsf_pkg.
`timescale 1ns / 1ps

module vcsf_scale (
  input  logic                          clk,
  input  logic                          en_mul,
  input  logic                          en_out,
  input  vcsf_pkg::cfg_t                cfg,
  input  vcsf_pkg::side_t               side_in,
  input  logic [vcsf_pkg::Q_W-1:0]      q_front,
  input  logic [vcsf_pkg::Q_W-1:0]      q_side,
  output vcsf_pkg::res_t                res
);

  localparam int LW = vcsf_pkg::LIM_W;
  localparam int PW = vcsf_pkg::PROD_W;
  localparam int SW = vcsf_pkg::SPD_W;

  logic [vcsf_pkg::FACT_W-1:0] fac_f, fac_s;
  logic [LW-1:0]               vmag, wmag, sat_f, mag_s;
  logic [SW-1:0]               wneg;
  logic [PW-1:0]               prod_f, prod_s;
  vcsf_pkg::side_t             side_m;
  vcsf_pkg::res_t              res_next;

  always_comb begin
    fac_f = (q_front < cfg.min_front_factor) ? cfg.min_front_factor : q_front;
    fac_s = (q_side < vcsf_pkg::SIDE_MIN_FACTOR) ? vcsf_pkg::SIDE_MIN_FACTOR : q_side;
    vmag  = side_in.vf[LW-1:0];
    wneg  = -side_in.ws;
    wmag  = side_in.ws[SW-1] ? wneg[LW-1:0] : side_in.ws[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_f <= PW'(vmag) * PW'(fac_f);
      prod_s <= PW'(wmag) * PW'(fac_s);
      side_m <= side_in;
    end
  end

  always_comb begin
    sat_f = prod_f[PW-1] ? {LW{1'b1}} : prod_f[PW-2:SW];
    mag_s = prod_s[PW-2:SW];
    res_next.linear_safe  = side_m.f_slow ? {1'b0, sat_f} : side_m.vf;
    if (!side_m.s_slow) res_next.angular_safe = side_m.ws;
    else if (side_m.ws[SW-1]) res_next.angular_safe = -{1'b0, mag_s};
    else res_next.angular_safe = {1'b0, mag_s};
    res_next.was_limited = side_m.limited;
    res_next.estop       = side_m.estop;
    res_next.cause       = side_m.cause;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/core/velocity_command_safety_filter.sv
// Top level of the velocity command safety filter: configuration registers,
// pipeline valid/advance control, decode, two band dividers and scaling.
// Depends on vcsf_pkg, vcsf_cmd_if, vcsf_safe_if, vcsf_decode, vcsf_div, vcsf_scale.
//
//   channel   kind          direction  payload
//   cmd       valid/ready   in         linear_cmd, angular_cmd, 3 dists, 3 good flags
//   safe      valid/ready   out        linear_safe, angular_safe, was_limited, estop, cause
//   apb       psel/penable  in/out     8 registers at byte address 4*index
//
// One word per cycle unless safe.ready stalls the pipeline; stages in order: decode,
// divider (2 quotient bits per stage for the 17-bit band factor), multiply, output.
// Every stage holds its word while the stage after it is full and stalled; a
// stage with no word takes a new one, so bubbles close up under a stall.
// rst clears the valid bits and loads the register reset values.
`timescale 1ns / 1ps

module velocity_command_safety_filter #(
  parameter int TURN_LIMIT_AT_STOP = 1000
) (
  input  logic                               clk,
  input  logic                               rst,
  vcsf_cmd_if.sink                           cmd,
  vcsf_safe_if.source                        safe,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vcsf_pkg::ADDR_W-1:0]        paddr,
  input  logic [vcsf_pkg::DATA_W-1:0]        pwdata,
  output logic [vcsf_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int NDIV = vcsf_pkg::DIV_STAGES;
  localparam int NST  = NDIV + 3;

  vcsf_pkg::cfg_t                cfg;
  logic [vcsf_pkg::IDX_W-1:0]    idx;
  logic                          wr;

  assign pready = 1'b1;
  assign idx    = paddr[vcsf_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= vcsf_pkg::CFG_RESET;
    end else if (wr) begin
      case (idx)
        vcsf_pkg::REG_MAX_LINEAR:      cfg.max_linear       <= pwdata[vcsf_pkg::LIM_W-1:0];
        vcsf_pkg::REG_MAX_ANGULAR:     cfg.max_angular      <= pwdata[vcsf_pkg::LIM_W-1:0];
        vcsf_pkg::REG_FRONT_STOP_DIST: cfg.front_stop_dist  <= pwdata[vcsf_pkg::DIST_W-1:0];
        vcsf_pkg::REG_FRONT_SLOW_DIST: cfg.front_slow_dist  <= pwdata[vcsf_pkg::DIST_W-1:0];
        vcsf_pkg::REG_SIDE_STOP_DIST:  cfg.side_stop_dist   <= pwdata[vcsf_pkg::DIST_W-1:0];
        vcsf_pkg::REG_SIDE_SLOW_DIST:  cfg.side_slow_dist   <= pwdata[vcsf_pkg::DIST_W-1:0];
        vcsf_pkg::REG_MIN_FRONT_FACT:  cfg.min_front_factor <= pwdata[vcsf_pkg::FACT_W-1:0];
        vcsf_pkg::REG_MODE_BITS:       cfg.mode_bits        <= pwdata[vcsf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      vcsf_pkg::REG_MAX_LINEAR:      prdata = vcsf_pkg::DATA_W'(cfg.max_linear);
      vcsf_pkg::REG_MAX_ANGULAR:     prdata = vcsf_pkg::DATA_W'(cfg.max_angular);
      vcsf_pkg::REG_FRONT_STOP_DIST: prdata = vcsf_pkg::DATA_W'(cfg.front_stop_dist);
      vcsf_pkg::REG_FRONT_SLOW_DIST: prdata = vcsf_pkg::DATA_W'(cfg.front_slow_dist);
      vcsf_pkg::REG_SIDE_STOP_DIST:  prdata = vcsf_pkg::DATA_W'(cfg.side_stop_dist);
      vcsf_pkg::REG_SIDE_SLOW_DIST:  prdata = vcsf_pkg::DATA_W'(cfg.side_slow_dist);
      vcsf_pkg::REG_MIN_FRONT_FACT:  prdata = vcsf_pkg::DATA_W'(cfg.min_front_factor);
      vcsf_pkg::REG_MODE_BITS:       prdata = vcsf_pkg::DATA_W'(cfg.mode_bits);
      default:                       prdata = '0;
    endcase
  end

  // pipeline control
  logic [NST-1:0] vld;
  logic [NST:0]   adv;

  assign adv[NST] = safe.ready;
  for (genvar i = 0; i < NST; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= cmd.valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign cmd.ready  = adv[0];
  assign safe.valid = vld[NST-1];

  vcsf_pkg::cmd_t               word;
  vcsf_pkg::side_t              dec_side;
  vcsf_pkg::side_t              side_d [NDIV];
  logic [vcsf_pkg::DIST_W-1:0]  f_num, f_den, s_num, s_den;
  logic [vcsf_pkg::Q_W-1:0]     q_front, q_side;
  vcsf_pkg::res_t               res;

  assign word = '{
    linear_cmd:  cmd.linear_cmd,
    angular_cmd: cmd.angular_cmd,
    front_dist:  cmd.front_dist,
    left_dist:   cmd.left_dist,
    right_dist:  cmd.right_dist,
    front_good:  cmd.front_good,
    left_good:   cmd.left_good,
    right_good:  cmd.right_good
  };

  vcsf_decode #(
    .TURN_LIMIT_AT_STOP(TURN_LIMIT_AT_STOP)
  ) u_decode (
    .clk   (clk),
    .en    (adv[0]),
    .word  (word),
    .cfg   (cfg),
    .side  (dec_side),
    .f_num (f_num),
    .f_den (f_den),
    .s_num (s_num),
    .s_den (s_den)
  );

  vcsf_div u_div_front (
    .clk (clk),
    .en  (adv[NDIV:1]),
    .num (f_num),
    .den (f_den),
    .quo (q_front)
  );

  vcsf_div u_div_side (
    .clk (clk),
    .en  (adv[NDIV:1]),
    .num (s_num),
    .den (s_den),
    .quo (q_side)
  );

  always_ff @(posedge clk) begin
    if (adv[1]) side_d[0] <= dec_side;
    for (int s = 1; s < NDIV; s++) begin
      if (adv[s+1]) side_d[s] <= side_d[s-1];
    end
  end

  vcsf_scale u_scale (
    .clk     (clk),
    .en_mul  (adv[NDIV+1]),
    .en_out  (adv[NDIV+2]),
    .cfg     (cfg),
    .side_in (side_d[NDIV-1]),
    .q_front (q_front),
    .q_side  (q_side),
    .res     (res)
  );

  assign safe.linear_safe  = res.linear_safe;
  assign safe.angular_safe = res.angular_safe;
  assign safe.was_limited  = res.was_limited;
  assign safe.estop        = res.estop;
  assign safe.cause        = res.cause;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline holds a word after reset");

  a_estop_zero: assert property (@(posedge clk) disable iff (rst)
    safe.valid && safe.estop |-> safe.linear_safe == '0)
    else $error("estop word with nonzero linear speed");

  a_cause_flag: assert property (@(posedge clk) disable iff (rst)
    safe.valid |-> (safe.cause == vcsf_pkg::CAUSE_NONE) == !safe.was_limited)
    else $error("cause and limited flag disagree");

  a_estop_cause: assert property (@(posedge clk) disable iff (rst)
    safe.valid && safe.estop |-> safe.cause == vcsf_pkg::CAUSE_LIMITED
      || safe.cause == vcsf_pkg::CAUSE_FRONT_INVALID
      || safe.cause == vcsf_pkg::CAUSE_FRONT_STOP)
    else $error("estop word with a cause outside the front rule");

  a_disabled_pass: assert property (@(posedge clk) disable iff (rst)
    safe.valid && !cfg.mode_bits[vcsf_pkg::MODE_ENABLE] |-> !safe.was_limited && !safe.estop)
    else $error("disabled filter altered a word");
`endif

endmodule

// File: verif/vcsf_filter_checker.sv
// Checker for the velocity command safety filter: follows register writes,
// predicts each filtered command word and compares it with the result channel.
// Depends on vcsf_pkg, vcsf_cmd_if and vcsf_safe_if.
`timescale 1ns / 1ps

module vcsf_filter_checker #(
  parameter int TURN_LIMIT = 1000
) (
  input  logic                        clk,
  input  logic                        rst,
  vcsf_cmd_if                         cmd,
  vcsf_safe_if                        safe,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [vcsf_pkg::ADDR_W-1:0] paddr,
  input  logic [vcsf_pkg::DATA_W-1:0] pwdata,
  output int                          pending,
  output int                          errors
);

  localparam int Q16_ONE = 65536;
  localparam int CW      = vcsf_pkg::CAUSE_W;
  localparam int SW      = vcsf_pkg::SPD_W;

  vcsf_pkg::cfg_t regs = vcsf_pkg::CFG_RESET;
  vcsf_pkg::res_t due_words[$];
  int             fail_count = 0;

  assign errors = fail_count;

  function automatic int clamp_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int band_factor(int reading, int near, int far, int lo);
    longint f;
    f = (longint'(reading - near) << 16) / longint'(far - near);
    if (f > Q16_ONE) f = Q16_ONE;
    else if (f < lo) f = lo;
    return int'(f);
  endfunction

  function automatic int scale_speed(int v, int f);
    longint mag, r;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    r = (mag * f) >>> 16;
    if (r > 32767) r = 32767;
    return (v < 0) ? -int'(r) : int'(r);
  endfunction

  function automatic void mark(inout bit lim, inout logic [CW-1:0] why,
                               input logic [CW-1:0] code);
    lim = 1'b1;
    if (why == vcsf_pkg::CAUSE_NONE) why = code;
  endfunction

  function automatic void side_rule(inout int w, input int reading, input bit good,
                                    input vcsf_pkg::cfg_t k, input logic [CW-1:0] stop_why,
                                    input logic [CW-1:0] invalid_why,
                                    inout bit lim, inout logic [CW-1:0] why);
    if (!(good && reading > 0)) begin
      if (k.mode_bits[vcsf_pkg::MODE_SIDE_FAIL]) begin
        w = 0;
        mark(lim, why, invalid_why);
      end
    end else if (reading <= int'(k.side_stop_dist)) begin
      w = 0;
      mark(lim, why, stop_why);
    end else if (reading <= int'(k.side_slow_dist)) begin
      w = scale_speed(w, band_factor(reading, int'(k.side_stop_dist),
                                     int'(k.side_slow_dist),
                                     int'(vcsf_pkg::SIDE_MIN_FACTOR)));
      mark(lim, why, vcsf_pkg::CAUSE_LIMITED);
    end
  endfunction

  function automatic vcsf_pkg::res_t filtered_command(vcsf_pkg::cmd_t c, vcsf_pkg::cfg_t k);
    int              v, w, cv, cw, fd;
    bit              lim, halted;
    logic [CW-1:0]   why;
    vcsf_pkg::res_t  r;
    v = int'($signed(c.linear_cmd));
    w = int'($signed(c.angular_cmd));
    fd = int'(c.front_dist);
    lim = 1'b0;
    halted = 1'b0;
    why = vcsf_pkg::CAUSE_NONE;
    if (k.mode_bits[vcsf_pkg::MODE_ENABLE]) begin
      cv = clamp_sym(v, int'(k.max_linear));
      cw = clamp_sym(w, int'(k.max_angular));
      if (cv != v || cw != w) mark(lim, why, vcsf_pkg::CAUSE_LIMITED);
      v = cv;
      w = cw;
      if (v > 0) begin
        if (!(c.front_good && fd > 0)) begin
          if (k.mode_bits[vcsf_pkg::MODE_FRONT_FAIL]) begin
            v = 0;
            halted = 1'b1;
            mark(lim, why, vcsf_pkg::CAUSE_FRONT_INVALID);
          end
        end else if (fd <= int'(k.front_stop_dist)) begin
          v = 0;
          halted = 1'b1;
          mark(lim, why, vcsf_pkg::CAUSE_FRONT_STOP);
          w = k.mode_bits[vcsf_pkg::MODE_TURN_STOP] ? clamp_sym(w, TURN_LIMIT) : 0;
        end else if (fd <= int'(k.front_slow_dist)) begin
          v = scale_speed(v, band_factor(fd, int'(k.front_stop_dist),
                                         int'(k.front_slow_dist),
                                         int'(k.min_front_factor)));
          mark(lim, why, vcsf_pkg::CAUSE_FRONT_SLOW);
        end
      end
      if (w > 0)
        side_rule(w, int'(c.left_dist), c.left_good, k, vcsf_pkg::CAUSE_LEFT_STOP,
                  vcsf_pkg::CAUSE_LEFT_INVALID, lim, why);
      if (w < 0)
        side_rule(w, int'(c.right_dist), c.right_good, k, vcsf_pkg::CAUSE_RIGHT_STOP,
                  vcsf_pkg::CAUSE_RIGHT_INVALID, lim, why);
    end
    r.linear_safe  = v[SW-1:0];
    r.angular_safe = w[SW-1:0];
    r.was_limited  = lim;
    r.estop        = halted;
    r.cause        = why;
    return r;
  endfunction

  task automatic check_field(string name, logic [SW-1:0] want, logic [SW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected 0x%h, got 0x%h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    vcsf_pkg::cmd_t seen;
    vcsf_pkg::res_t want, got;
    if (rst) begin
      regs = vcsf_pkg::CFG_RESET;
      due_words.delete();
    end else begin
      if (safe.valid && safe.ready) begin
        got.linear_safe  = safe.linear_safe;
        got.angular_safe = safe.angular_safe;
        got.was_limited  = safe.was_limited;
        got.estop        = safe.estop;
        got.cause        = safe.cause;
        if (due_words.size() == 0) begin
          fail_count++;
          $display("%0t: word expected none, got 0x%h", $time, got);
        end else begin
          want = due_words.pop_front();
          check_field("linear_safe", want.linear_safe, got.linear_safe);
          check_field("angular_safe", want.angular_safe, got.angular_safe);
          check_field("was_limited", SW'(want.was_limited), SW'(got.was_limited));
          check_field("estop", SW'(want.estop), SW'(got.estop));
          check_field("cause", SW'(want.cause), SW'(got.cause));
        end
      end
      if (cmd.valid && cmd.ready) begin
        seen.linear_cmd  = cmd.linear_cmd;
        seen.angular_cmd = cmd.angular_cmd;
        seen.front_dist  = cmd.front_dist;
        seen.left_dist   = cmd.left_dist;
        seen.right_dist  = cmd.right_dist;
        seen.front_good  = cmd.front_good;
        seen.left_good   = cmd.left_good;
        seen.right_good  = cmd.right_good;
        due_words.push_back(filtered_command(seen, regs));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[vcsf_pkg::ADDR_W-1:2])
          vcsf_pkg::REG_MAX_LINEAR:
            regs.max_linear = pwdata[vcsf_pkg::LIM_W-1:0];
          vcsf_pkg::REG_MAX_ANGULAR:
            regs.max_angular = pwdata[vcsf_pkg::LIM_W-1:0];
          vcsf_pkg::REG_FRONT_STOP_DIST:
            regs.front_stop_dist = pwdata[vcsf_pkg::DIST_W-1:0];
          vcsf_pkg::REG_FRONT_SLOW_DIST:
            regs.front_slow_dist = pwdata[vcsf_pkg::DIST_W-1:0];
          vcsf_pkg::REG_SIDE_STOP_DIST:
            regs.side_stop_dist = pwdata[vcsf_pkg::DIST_W-1:0];
          vcsf_pkg::REG_SIDE_SLOW_DIST:
            regs.side_slow_dist = pwdata[vcsf_pkg::DIST_W-1:0];
          vcsf_pkg::REG_MIN_FRONT_FACT:
            regs.min_front_factor = pwdata[vcsf_pkg::FACT_W-1:0];
          vcsf_pkg::REG_MODE_BITS:
            regs.mode_bits = pwdata[vcsf_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= due_words.size();
  end

endmodule

// File: verif/velocity_command_safety_filter_tb.sv
// Top of the velocity command safety filter testbench: clock, reset, register
// setup, command stimulus with idle and stall phases, and the verdict.
// Depends on vcsf_pkg, the channel interfaces, the block and vcsf_filter_checker.
`timescale 1ns / 1ps

module velocity_command_safety_filter_tb;

  localparam int TURN_LIMIT      = 1000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TAIL_CYCLES     = 20;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic                        pready;
  logic [vcsf_pkg::ADDR_W-1:0] paddr;
  logic [vcsf_pkg::DATA_W-1:0] pwdata;
  logic [vcsf_pkg::DATA_W-1:0] prdata;
  int                          idle_pct = 0;
  int                          stall_pct = 0;
  int                          pending;
  int                          errors;

  vcsf_cmd_if  cmd ();
  vcsf_safe_if safe ();

  velocity_command_safety_filter #(
    .TURN_LIMIT_AT_STOP(TURN_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .safe(safe),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  vcsf_filter_checker #(
    .TURN_LIMIT(TURN_LIMIT)
  ) chk (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .safe(safe),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .pending(pending),
    .errors(errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      safe.ready <= 1'b0;
    end else begin
      safe.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(64'd5_000_000);
    $display("velocity_command_safety_filter regression: fail");
    $finish;
  end

  function automatic vcsf_pkg::cmd_t command_word(int v, int w, int fd, int ld, int rd,
                                                  bit fg, bit lg, bit rg);
    vcsf_pkg::cmd_t c;
    c.linear_cmd  = v[vcsf_pkg::SPD_W-1:0];
    c.angular_cmd = w[vcsf_pkg::SPD_W-1:0];
    c.front_dist  = fd[vcsf_pkg::DIST_W-1:0];
    c.left_dist   = ld[vcsf_pkg::DIST_W-1:0];
    c.right_dist  = rd[vcsf_pkg::DIST_W-1:0];
    c.front_good  = fg;
    c.left_good   = lg;
    c.right_good  = rg;
    return c;
  endfunction

  function automatic int pick_speed(int lim);
    case ($urandom_range(5))
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(2 * lim)) - lim;
      2: return ($urandom_range(1) ? 1 : -1) * (lim + int'($urandom_range(1)));
      3: return int'($urandom_range(200)) - 100;
      4: return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom_range(2)) - 1;
    endcase
  endfunction

  function automatic int pick_dist(int near, int far);
    int d;
    case ($urandom_range(5))
      0: return 0;
      1: return int'($urandom_range(near, 1));
      2: return (far > near) ? int'($urandom_range(far, near + 1)) : int'($urandom_range(65535));
      3: begin
        d = ($urandom_range(1) ? near : far) + int'($urandom_range(1));
        return (d > 65535) ? 65535 : d;
      end
      4: return (far < 65535) ? int'($urandom_range(65535, far + 1)) : 65535;
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  function automatic int slow_above(int near);
    int d;
    if ($urandom_range(4) == 0) return int'($urandom_range(near, 1));
    d = near + int'($urandom_range(5000, 1));
    return (d > 65535) ? 65535 : d;
  endfunction

  function automatic vcsf_pkg::cfg_t phase_config(int p);
    vcsf_pkg::cfg_t k;
    k = vcsf_pkg::CFG_RESET;
    case (p)
      0: ;
      1: k = '{15'd32767, 15'd32767, 16'd1, 16'd65535, 16'd1, 16'd65535, 17'd0, 4'b1111};
      2: k = '{15'd0, 15'd32767, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 17'd65536,
               4'b0101};
      3: k = '{15'd32767, 15'd32767, 16'd100, 16'd2000, 16'd50, 16'd1000, 17'd65536,
               4'b1011};
      default: begin
        k.max_linear       = 15'($urandom_range(1) ? $urandom_range(3000)
                                                   : $urandom_range(32767));
        k.max_angular      = 15'($urandom_range(1) ? $urandom_range(3000)
                                                   : $urandom_range(32767));
        k.front_stop_dist  = 16'($urandom_range(3000, 1));
        k.front_slow_dist  = 16'(slow_above(int'(k.front_stop_dist)));
        k.side_stop_dist   = 16'($urandom_range(3000, 1));
        k.side_slow_dist   = 16'(slow_above(int'(k.side_stop_dist)));
        k.min_front_factor = 17'($urandom_range(65536));
        k.mode_bits        = (p == 4) ? 4'b0000 : (p == 5) ? 4'b0111
                                                           : 4'($urandom_range(15));
      end
    endcase
    return k;
  endfunction

  task automatic send_cmd(vcsf_pkg::cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.linear_cmd  <= c.linear_cmd;
    cmd.angular_cmd <= c.angular_cmd;
    cmd.front_dist  <= c.front_dist;
    cmd.left_dist   <= c.left_dist;
    cmd.right_dist  <= c.right_dist;
    cmd.front_good  <= c.front_good;
    cmd.left_good   <= c.left_good;
    cmd.right_good  <= c.right_good;
    do @(posedge clk); while (!cmd.ready);
  endtask

  task automatic finish_outstanding();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [vcsf_pkg::IDX_W-1:0] idx,
                           logic [vcsf_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(vcsf_pkg::cfg_t k);
    write_reg(vcsf_pkg::REG_MAX_LINEAR, vcsf_pkg::DATA_W'(k.max_linear));
    write_reg(vcsf_pkg::REG_MAX_ANGULAR, vcsf_pkg::DATA_W'(k.max_angular));
    write_reg(vcsf_pkg::REG_FRONT_STOP_DIST, vcsf_pkg::DATA_W'(k.front_stop_dist));
    write_reg(vcsf_pkg::REG_FRONT_SLOW_DIST, vcsf_pkg::DATA_W'(k.front_slow_dist));
    write_reg(vcsf_pkg::REG_SIDE_STOP_DIST, vcsf_pkg::DATA_W'(k.side_stop_dist));
    write_reg(vcsf_pkg::REG_SIDE_SLOW_DIST, vcsf_pkg::DATA_W'(k.side_slow_dist));
    write_reg(vcsf_pkg::REG_MIN_FRONT_FACT, vcsf_pkg::DATA_W'(k.min_front_factor));
    write_reg(vcsf_pkg::REG_MODE_BITS, vcsf_pkg::DATA_W'(k.mode_bits));
  endtask

  initial begin
    vcsf_pkg::cfg_t k;
    int             p;
    int             n;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    cmd.valid       = 1'b0;
    cmd.linear_cmd  = '0;
    cmd.angular_cmd = '0;
    cmd.front_dist  = '0;
    cmd.left_dist   = '0;
    cmd.right_dist  = '0;
    cmd.front_good  = 1'b0;
    cmd.left_good   = 1'b0;
    cmd.right_good  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_cmd(command_word(0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(command_word(32767, 32767, 65535, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(-32768, -32768, 65535, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(400, 0, 1000, 0, 0, 0, 1, 1));
    send_cmd(command_word(400, 0, 0, 1000, 1000, 1, 1, 1));
    send_cmd(command_word(400, 1500, 300, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(400, -1500, 1, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(400, 0, 301, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(400, 0, 800, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(400, 0, 550, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(-400, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(command_word(0, 1000, 65535, 500, 65535, 1, 0, 1));
    send_cmd(command_word(0, 1000, 65535, 200, 65535, 1, 1, 1));
    send_cmd(command_word(0, 1000, 65535, 350, 65535, 1, 1, 1));
    send_cmd(command_word(0, -1000, 65535, 65535, 0, 1, 1, 1));
    send_cmd(command_word(0, -1000, 65535, 65535, 150, 1, 1, 1));
    send_cmd(command_word(0, -1000, 65535, 65535, 500, 1, 1, 1));
    send_cmd(command_word(400, -1500, 100, 65535, 100, 1, 1, 1));
    finish_outstanding();
    write_reg(vcsf_pkg::REG_MODE_BITS, vcsf_pkg::DATA_W'(1 << vcsf_pkg::MODE_ENABLE));
    send_cmd(command_word(400, 1500, 0, 0, 0, 0, 0, 0));
    send_cmd(command_word(400, 1500, 100, 65535, 65535, 1, 1, 1));
    send_cmd(command_word(0, -1000, 65535, 65535, 0, 1, 1, 0));
    finish_outstanding();
    write_reg(vcsf_pkg::REG_MODE_BITS, '0);
    send_cmd(command_word(32767, -32768, 0, 0, 0, 0, 0, 0));

    for (p = 0; p < PHASES; p++) begin
      k = phase_config(p);
      finish_outstanding();
      load_config(k);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 87;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 87;
        end
        default: begin
          idle_pct  = 17;
          stall_pct = 17;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) finish_outstanding();
        send_cmd(command_word(pick_speed(int'(k.max_linear)),
                              pick_speed(int'(k.max_angular)),
                              pick_dist(int'(k.front_stop_dist), int'(k.front_slow_dist)),
                              pick_dist(int'(k.side_stop_dist), int'(k.side_slow_dist)),
                              pick_dist(int'(k.side_stop_dist), int'(k.side_slow_dist)),
                              $urandom_range(9) != 0, $urandom_range(9) != 0,
                              $urandom_range(9) != 0));
      end
    end

    finish_outstanding();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("velocity_command_safety_filter regression: pass");
    end else begin
      $display("velocity_command_safety_filter regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/vcsf_pkg.sv
rtl/core/vcsf_cmd_if.sv
rtl/core/vcsf_safe_if.sv
rtl/core/vcsf_decode.sv
rtl/core/vcsf_div.sv
rtl/core/vcsf_scale.sv
rtl/core/velocity_command_safety_filter.sv
verif/vcsf_filter_checker.sv
verif/velocity_command_safety_filter_tb.sv
